// ----- hw/rtl/masked_stencil_smoother_3x3_assert.svh -----
// Assertion macros used by the checker file of the smoother.
`ifndef MASKED_STENCIL_SMOOTHER_3X3_ASSERT_SVH
`define MASKED_STENCIL_SMOOTHER_3X3_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define MSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define MSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/mss_pkg.sv -----
// ----------------------------------------------------------------------------
// mss_pkg
// Shared constants, weights and controller/datapath interface types of the
// masked 3x3 stencil smoother.
// ----------------------------------------------------------------------------
package mss_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int THICK_W            = 16;
   localparam int LAYER_W            = 8;
   localparam int SPACING_W          = 16;
   localparam int DEPTH_W            = LAYER_W + SPACING_W;
   localparam int NEXT_W             = DEPTH_W + 1;
   localparam int W_W                = 13;
   localparam int DENOM_W            = 16;
   localparam int CELL_W             = 4;
   localparam int CELLS              = 9;

   localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(10);

   // Q0.16 weights of the outer product of [0.35 0.30 0.35].
   localparam logic [W_W-1:0] W_CORNER = W_W'(8028);
   localparam logic [W_W-1:0] W_EDGE   = W_W'(6881);
   localparam logic [W_W-1:0] W_CENTRE = W_W'(5898);

   typedef struct packed {
      logic              capture;
      logic              calc_depth;
      logic              start_pass;
      logic              pass;
      logic              mac_en;
      logic [CELL_W-1:0] cell_idx;
      logic              abs_en;
      logic              pre_en;
      logic              div_step;
      logic              out_load;
      logic              win_update;
   } cmd_type;

   typedef struct packed {
      logic has_prev;
      logic row_end;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [1:0] col;
      logic [1:0] row;
   } cell_pos_type;

   // Cells are visited column by column, top row first.
   function automatic cell_pos_type cell_pos(input logic [CELL_W-1:0] cell_idx);
      cell_pos_type p;
      case (cell_idx)
         CELL_W'(0): p = '{col: 2'd0, row: 2'd0};
         CELL_W'(1): p = '{col: 2'd0, row: 2'd1};
         CELL_W'(2): p = '{col: 2'd0, row: 2'd2};
         CELL_W'(3): p = '{col: 2'd1, row: 2'd0};
         CELL_W'(4): p = '{col: 2'd1, row: 2'd1};
         CELL_W'(5): p = '{col: 2'd1, row: 2'd2};
         CELL_W'(6): p = '{col: 2'd2, row: 2'd0};
         CELL_W'(7): p = '{col: 2'd2, row: 2'd1};
         CELL_W'(8): p = '{col: 2'd2, row: 2'd2};
         default:    p = '{col: 2'd0, row: 2'd0};
      endcase
      return p;
   endfunction

   function automatic logic [W_W-1:0] cell_weight(input cell_pos_type p);
      logic mid_col;
      logic mid_row;
      mid_col = (p.col == 2'd1);
      mid_row = (p.row == 2'd1);
      if (mid_col && mid_row) begin
         return W_CENTRE;
      end else if (mid_col || mid_row) begin
         return W_EDGE;
      end
      return W_CORNER;
   endfunction

endpackage

// ----- hw/rtl/mss_ctrl.sv -----
// ----------------------------------------------------------------------------
// mss_ctrl
// Sequencer of the smoother: accepts a request, runs zero, one or two passes of
// multiply-accumulate and division, and hands each result to the output.
// ----------------------------------------------------------------------------
module mss_ctrl #(
   parameter int DATA_WIDTH = mss_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mss_pkg::status_type status,
   output mss_pkg::cmd_type    cmd
);

   localparam int CNT_W = $clog2(DATA_WIDTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEPTH,
      ST_START,
      ST_MAC,
      ST_DRAIN,
      ST_ABS,
      ST_PRE,
      ST_DIV,
      ST_WRITE,
      ST_UPDATE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pass_ff, pass_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pass_in  = pass_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DEPTH;
            end
         end
         ST_DEPTH: begin
            // The first column of a row yields a result only if it also ends the row.
            if (status.has_prev) begin
               pass_in  = 1'b0;
               state_in = ST_START;
            end else if (status.row_end) begin
               pass_in  = 1'b1;
               state_in = ST_START;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_START: begin
            cnt_in   = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (cnt_ff == CNT_W'(mss_pkg::CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: state_in = ST_ABS;
         ST_ABS:   state_in = ST_PRE;
         ST_PRE: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DATA_WIDTH)) begin
               state_in = ST_WRITE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_WRITE: begin
            if (status.out_free) begin
               if (!pass_ff && status.row_end) begin
                  pass_in  = 1'b1;
                  state_in = ST_START;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pass_ff  <= pass_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.capture    = (state_ff == ST_IDLE) && req_valid;
      cmd.calc_depth = (state_ff == ST_DEPTH);
      cmd.start_pass = (state_ff == ST_START);
      cmd.pass       = pass_ff;
      cmd.mac_en     = (state_ff == ST_MAC);
      cmd.cell_idx   = cnt_ff[mss_pkg::CELL_W-1:0];
      cmd.abs_en     = (state_ff == ST_ABS);
      cmd.pre_en     = (state_ff == ST_PRE);
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.out_load   = (state_ff == ST_WRITE) && status.out_free;
      cmd.win_update = (state_ff == ST_UPDATE);
   end

endmodule

// ----- hw/rtl/mss_datapath.sv -----
// ----------------------------------------------------------------------------
// mss_datapath
// Column window, serial multiply-accumulate with denominator build-up,
// restoring divider with saturation, output register and spacing register.
// ----------------------------------------------------------------------------
module mss_datapath #(
   parameter int DATA_WIDTH = mss_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mss_pkg::cmd_type                     cmd,
   output mss_pkg::status_type                  status,
   input  logic signed [DATA_WIDTH-1:0]         req_heat_above,
   input  logic signed [DATA_WIDTH-1:0]         req_heat_mid,
   input  logic signed [DATA_WIDTH-1:0]         req_heat_below,
   input  logic [mss_pkg::THICK_W-1:0]          req_thick_above,
   input  logic [mss_pkg::THICK_W-1:0]          req_thick_mid,
   input  logic [mss_pkg::THICK_W-1:0]          req_thick_below,
   input  logic [mss_pkg::LAYER_W-1:0]          req_layer,
   input  logic                                 req_row_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [DATA_WIDTH-1:0]         rsp_smoothed,
   output logic                                 rsp_last_of_row,
   input  logic                                 csr_wr_en,
   input  logic [mss_pkg::SPACING_W-1:0]        csr_wr_data
);

   localparam int DW      = DATA_WIDTH;
   localparam int TW      = mss_pkg::THICK_W;
   localparam int WW      = mss_pkg::W_W;
   localparam int DNW     = mss_pkg::DENOM_W;
   localparam int SUM_W   = DW + DNW + 1;
   localparam int MAG_W   = DW + DNW;
   localparam int PROD_W  = DW + WW + 1;

   // Spacing register.
   logic [mss_pkg::SPACING_W-1:0] spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= mss_pkg::SPACING_RESET;
      end else if (csr_wr_en) begin
         spacing_ff <= csr_wr_data;
      end
   end

   // Current column and the two stored columns.
   logic signed [DW-1:0] cur_heat_ff [3];
   logic [TW-1:0]        cur_thick_ff [3];
   logic signed [DW-1:0] old_heat_ff [3];
   logic [TW-1:0]        old_thick_ff [3];
   logic signed [DW-1:0] new_heat_ff [3];
   logic [TW-1:0]        new_thick_ff [3];
   logic [mss_pkg::LAYER_W-1:0] layer_ff;
   logic                 row_end_ff;
   logic [1:0]           seen_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_heat_ff[0]  <= req_heat_above;
         cur_heat_ff[1]  <= req_heat_mid;
         cur_heat_ff[2]  <= req_heat_below;
         cur_thick_ff[0] <= req_thick_above;
         cur_thick_ff[1] <= req_thick_mid;
         cur_thick_ff[2] <= req_thick_below;
         layer_ff        <= req_layer;
         row_end_ff      <= req_row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.win_update) begin
         for (int r = 0; r < 3; r++) begin
            if (row_end_ff) begin
               old_heat_ff[r]  <= '0;
               old_thick_ff[r] <= '0;
               new_heat_ff[r]  <= '0;
               new_thick_ff[r] <= '0;
            end else begin
               old_heat_ff[r]  <= new_heat_ff[r];
               old_thick_ff[r] <= new_thick_ff[r];
               new_heat_ff[r]  <= cur_heat_ff[r];
               new_thick_ff[r] <= cur_thick_ff[r];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 2'd0;
      end else if (cmd.win_update) begin
         if (row_end_ff) begin
            seen_ff <= 2'd0;
         end else if (seen_ff != 2'd2) begin
            seen_ff <= seen_ff + 2'd1;
         end
      end
   end

   // Layer depth and the depth of the next layer.
   logic [mss_pkg::DEPTH_W-1:0] depth_ff;
   logic [mss_pkg::NEXT_W-1:0]  next_ff;
   logic [mss_pkg::DEPTH_W-1:0] depth_full;
   logic [mss_pkg::NEXT_W-1:0]  next_full;

   assign depth_full = mss_pkg::DEPTH_W'(layer_ff) * mss_pkg::DEPTH_W'(spacing_ff);
   assign next_full  = (mss_pkg::NEXT_W'(layer_ff) + mss_pkg::NEXT_W'(1))
                       * mss_pkg::NEXT_W'(spacing_ff);

   always_ff @(posedge clock) begin
      if (cmd.calc_depth) begin
         depth_ff <= depth_full;
         next_ff  <= next_full;
      end
   end

   // Cell selection for the current pass.
   mss_pkg::cell_pos_type pos;
   logic                  present;
   logic signed [DW-1:0]  sel_heat;
   logic [TW-1:0]         sel_thick;
   logic [WW-1:0]         weight;
   logic                  active;

   always_comb begin
      pos       = mss_pkg::cell_pos(cmd.cell_idx);
      present   = 1'b0;
      sel_heat  = '0;
      sel_thick = '0;
      if (!cmd.pass) begin
         case (pos.col)
            2'd0: begin
               present   = (seen_ff == 2'd2);
               sel_heat  = old_heat_ff[pos.row];
               sel_thick = old_thick_ff[pos.row];
            end
            2'd1: begin
               present   = 1'b1;
               sel_heat  = new_heat_ff[pos.row];
               sel_thick = new_thick_ff[pos.row];
            end
            default: begin
               present   = 1'b1;
               sel_heat  = cur_heat_ff[pos.row];
               sel_thick = cur_thick_ff[pos.row];
            end
         endcase
      end else begin
         // Closing pass: the column beyond the row end is absent.
         case (pos.col)
            2'd0: begin
               present   = (seen_ff != 2'd0);
               sel_heat  = new_heat_ff[pos.row];
               sel_thick = new_thick_ff[pos.row];
            end
            2'd1: begin
               present   = 1'b1;
               sel_heat  = cur_heat_ff[pos.row];
               sel_thick = cur_thick_ff[pos.row];
            end
            default: begin
               present = 1'b0;
            end
         endcase
      end
      if (!present) begin
         sel_heat = '0;
      end
      weight = mss_pkg::cell_weight(pos);
      active = present && !(pos.col == 2'd1 && pos.row == 2'd1)
               && (mss_pkg::DEPTH_W'(sel_thick) >= depth_ff);
   end

   // Multiply-accumulate, one cell per cycle, product registered first.
   logic signed [WW:0]       weight_s;
   logic signed [PROD_W-1:0] prod_full;
   logic signed [SUM_W-1:0]  prod_ff;
   logic [DNW-1:0]           wadd_ff;
   logic                     prod_vld_ff;
   logic signed [SUM_W-1:0]  acc_ff;
   logic [DNW-1:0]           denom_ff;

   assign weight_s  = $signed({1'b0, weight});
   assign prod_full = sel_heat * weight_s;

   always_ff @(posedge clock) begin
      prod_ff <= SUM_W'(prod_full);
      wadd_ff <= active ? DNW'(weight) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mac_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_pass) begin
         acc_ff   <= '0;
         denom_ff <= DNW'(mss_pkg::W_CENTRE);
      end else if (prod_vld_ff) begin
         acc_ff   <= acc_ff + prod_ff;
         denom_ff <= denom_ff + wadd_ff;
      end
   end

   // Magnitude, overflow pre-check and restoring division.
   logic             neg_ff;
   logic [MAG_W-1:0] mag_ff;
   logic [DNW-1:0]   rem_ff;
   logic [DW:0]      sh_ff;
   logic [DW:0]      q_ff;
   logic             ovf_ff;
   logic [SUM_W-1:0] acc_neg;
   logic [DNW:0]     trial;
   logic             fits;

   assign acc_neg = SUM_W'(-acc_ff);
   assign trial   = {rem_ff, sh_ff[DW]};
   assign fits    = (trial >= {1'b0, denom_ff});

   always_ff @(posedge clock) begin
      if (cmd.abs_en) begin
         neg_ff <= acc_ff[SUM_W-1];
         mag_ff <= acc_ff[SUM_W-1] ? acc_neg[MAG_W-1:0] : MAG_W'(acc_ff);
      end
      if (cmd.pre_en) begin
         // A quotient of 2**(DW+1) or more saturates whatever its low bits.
         rem_ff <= DNW'(mag_ff[MAG_W-1:DW+1]);
         ovf_ff <= (DNW'(mag_ff[MAG_W-1:DW+1]) >= denom_ff);
         sh_ff  <= mag_ff[DW:0];
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= fits ? DNW'(trial - {1'b0, denom_ff}) : trial[DNW-1:0];
         sh_ff  <= {sh_ff[DW-1:0], 1'b0};
         q_ff   <= {q_ff[DW-1:0], fits};
      end
   end

   // Saturation and the center depth test.
   logic                 skip;
   logic                 pos_sat;
   logic                 neg_sat;
   logic [DW:0]          q_neg;
   logic signed [DW-1:0] result;

   assign q_neg   = -q_ff;
   assign skip    = (next_ff > mss_pkg::NEXT_W'(cmd.pass ? cur_thick_ff[1]
                                                          : new_thick_ff[1]));
   assign pos_sat = ovf_ff || q_ff[DW] || q_ff[DW-1];
   assign neg_sat = ovf_ff || q_ff[DW] || (q_ff[DW-1] && (|q_ff[DW-2:0]));

   always_comb begin
      if (skip) begin
         result = '0;
      end else if (neg_ff) begin
         result = neg_sat ? $signed({1'b1, {(DW-1){1'b0}}}) : $signed(q_neg[DW-1:0]);
      end else begin
         result = pos_sat ? $signed({1'b0, {(DW-1){1'b1}}}) : $signed(q_ff[DW-1:0]);
      end
   end

   // Output register.
   logic                 rsp_valid_ff;
   logic signed [DW-1:0] smoothed_ff;
   logic                 last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         smoothed_ff <= result;
         last_ff     <= cmd.pass;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_smoothed    = smoothed_ff;
   assign rsp_last_of_row = last_ff;

   assign status.has_prev = (seen_ff != 2'd0);
   assign status.row_end  = row_end_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

// ----- hw/rtl/masked_stencil_smoother_3x3.sv -----
// ----------------------------------------------------------------------------
// masked_stencil_smoother_3x3
// Masked 3x3 weighted smoother of one depth layer of a heating field.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the req_ channel carries one grid column (above, center and
// below samples of heat and thickness), its layer index and a row-end flag.
// Results leave on the rsp_ channel; rsp_last_of_row marks the result of the
// final column of a row. A request yields the result of the previous column,
// and a row-end request also yields its own, so one request gives zero, one
// or two results. csr_wr_en writes the layer spacing; the user must write it
// only while the block is idle, since the block itself does not enforce this.
// Operation: every result runs a multiply-accumulate over the nine cells,
// then a restoring divider that retires one quotient bit a cycle until all
// DATA_WIDTH + 1 quotient bits are in. The divider sets the rate; requests
// are handled one at a time.
// A finished result waits in the output register; a stalled receiver holds
// the block only when the next result is ready to be written.
// Reset marks the column window empty, drops any pending result and sets the spacing to 10.
// ----------------------------------------------------------------------------
module masked_stencil_smoother_3x3 #(
   parameter int DATA_WIDTH = mss_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [DATA_WIDTH-1:0]  req_heat_above,
   input  logic signed [DATA_WIDTH-1:0]  req_heat_mid,
   input  logic signed [DATA_WIDTH-1:0]  req_heat_below,
   input  logic [mss_pkg::THICK_W-1:0]   req_thick_above,
   input  logic [mss_pkg::THICK_W-1:0]   req_thick_mid,
   input  logic [mss_pkg::THICK_W-1:0]   req_thick_below,
   input  logic [mss_pkg::LAYER_W-1:0]   req_layer,
   input  logic                          req_row_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DATA_WIDTH-1:0]  rsp_smoothed,
   output logic                          rsp_last_of_row,
   input  logic                          csr_wr_en,
   input  logic [mss_pkg::SPACING_W-1:0] csr_wr_data
);

   mss_pkg::cmd_type    cmd;
   mss_pkg::status_type status;

   mss_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mss_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_heat_above  (req_heat_above),
      .req_heat_mid    (req_heat_mid),
      .req_heat_below  (req_heat_below),
      .req_thick_above (req_thick_above),
      .req_thick_mid   (req_thick_mid),
      .req_thick_below (req_thick_below),
      .req_layer       (req_layer),
      .req_row_end     (req_row_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_smoothed    (rsp_smoothed),
      .rsp_last_of_row (rsp_last_of_row),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

endmodule

// ----- hw/rtl/mss_checker.sv -----
// ----------------------------------------------------------------------------
// mss_checker
// Port-level assertions of the smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "masked_stencil_smoother_3x3_assert.svh"

module mss_checker #(
   parameter int DATA_WIDTH = mss_pkg::DATA_WIDTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [DATA_WIDTH-1:0]  rsp_smoothed,
   input logic                          rsp_last_of_row
);

   // A stalled result keeps its value and its row-end flag.
   `MSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_smoothed) && $stable(rsp_last_of_row),
      "stalled result changed")

   // Reset leaves the block ready and with no result pending.
   `MSS_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset,
      req_ready && !rsp_valid, "block not idle after reset")

   // Requests are taken one at a time.
   `MSS_ASSERT_NEXT(a_one_request, clock, reset, req_valid && req_ready,
      !req_ready, "request accepted while another is in work")

   // A new result appears only while a request is still in work.
   `MSS_ASSERT_NOW(a_rsp_in_work, clock, reset, $rose(rsp_valid),
      !req_ready, "result appeared while the block was idle")

endmodule

bind masked_stencil_smoother_3x3 mss_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_mss_checker (.*);
